// ----- rtl/gse_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// gse_pkg: shared widths, register indexes and types
// Constants and types shared by the Golomb encoder's modules.
// ---------------------------------------------------------------------------
package gse_pkg;

  localparam int VALUE_BITS_DEF = 16;   // default sample width
  localparam int DIV_W          = 16;   // golomb divisor width
  localparam int LOG_W          = 5;    // ceil(log2 m), 0..16
  localparam int ONES_W         = 17;
  localparam int CODE_W         = 16;
  localparam int LEN_W          = 5;
  localparam int TOTAL_W        = 17;
  localparam int OUT_FIELDS_W   = ONES_W + CODE_W + LEN_W + TOTAL_W;
  localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_ADDR_W     = 1;
  localparam int CFG_DATA_W     = 16;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_GOLOMB_DIVISOR = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NEGATIVE_MODE  = 1'd1;

  // settings as seen by the datapath, with derived code parameters
  typedef struct packed {
    logic [DIV_W-1:0] divisor;     // m, zero already replaced by one
    logic             zigzag;      // negative_mode
    logic [LOG_W-1:0] log_m;       // b = ceil(log2 m)
    logic [DIV_W-1:0] thresh;      // t = 2^b - m
  } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/gse_cfg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// gse_cfg: configuration registers
// Holds the divisor and mapping mode and derives b and t at write time.
// ---------------------------------------------------------------------------
module gse_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [gse_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [gse_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output gse_pkg::cfg_t                         cfg
);

  localparam int DW = gse_pkg::DIV_W;
  localparam int LW = gse_pkg::LOG_W;

  gse_pkg::cfg_t cfg_r;

  logic [DW-1:0] m_nxt;
  logic [DW-1:0] m_dec;
  logic [LW-1:0] b_nxt;
  logic [DW:0]   pow_b;
  logic [DW:0]   t_wide;

  // zero divisor behaves as one
  assign m_nxt = (cfg_wdata[DW-1:0] == '0) ? DW'(1) : cfg_wdata[DW-1:0];
  assign m_dec = m_nxt - DW'(1);

  // ceil(log2 m) is the bit length of m - 1
  always_comb begin
    b_nxt = '0;
    for (int i = 0; i < DW; i++) begin
      if (m_dec[i]) begin
        b_nxt = LW'(i + 1);
      end
    end
  end

  assign pow_b  = (DW+1)'(1) << b_nxt;
  assign t_wide = pow_b - {1'b0, m_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.divisor <= DW'(1);
      cfg_r.zigzag  <= 1'b0;
      cfg_r.log_m   <= '0;
      cfg_r.thresh  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        gse_pkg::REG_GOLOMB_DIVISOR: begin
          cfg_r.divisor <= m_nxt;
          cfg_r.log_m   <= b_nxt;
          cfg_r.thresh  <= t_wide[DW-1:0];
        end
        gse_pkg::REG_NEGATIVE_MODE: begin
          cfg_r.zigzag <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- rtl/gse_map.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// gse_map: signed to non-negative mapping stage
// Sign-magnitude or zigzag mapping of one sample, registered.
// ---------------------------------------------------------------------------
module gse_map #(
  parameter int VALUE_BITS = gse_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  zigzag,
  input  wire logic                  in_vld,
  input  wire logic [VALUE_BITS-1:0] sample,
  output logic                       map_vld,
  output logic [VALUE_BITS:0]        map_val
);

  logic                  vld_r;
  logic [VALUE_BITS:0]   val_r;
  logic [VALUE_BITS:0]   val_nxt;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;

  assign neg = sample[VALUE_BITS-1];
  // two's complement negate; the most negative code maps to 2^(VALUE_BITS-1)
  assign mag = neg ? (~sample + VALUE_BITS'(1)) : sample;

  always_comb begin
    if (!zigzag) begin
      val_nxt = {mag, neg};
    end else if (neg) begin
      val_nxt = {mag, 1'b0} - (VALUE_BITS+1)'(1);
    end else begin
      val_nxt = {mag, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
    end
  end

  assign map_vld = vld_r;
  assign map_val = val_r;

endmodule
`default_nettype wire

// ----- rtl/gse_div.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// gse_div: pipelined restoring divider
// One quotient bit per stage; the dividend word shifts out while the
// quotient shifts in.
// ---------------------------------------------------------------------------
module gse_div #(
  parameter int VALUE_BITS = gse_pkg::VALUE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic [gse_pkg::DIV_W-1:0]  divisor,
  input  wire logic                       dvd_vld,
  input  wire logic [VALUE_BITS:0]        dvd,
  output logic                            quo_vld,
  output logic [VALUE_BITS:0]             quo,
  output logic [gse_pkg::DIV_W-1:0]       rem
);

  localparam int NW = VALUE_BITS + 1;   // mapped value width, one stage per bit
  localparam int DW = gse_pkg::DIV_W;

  logic          vld_r  [NW];
  logic [NW-1:0] word_r [NW];
  logic [DW-1:0] rem_r  [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic          vld_in;
    logic [NW-1:0] word_in;
    logic [DW-1:0] rem_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign vld_in  = dvd_vld;
      assign word_in = dvd;
      assign rem_in  = '0;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign word_in = word_r[s-1];
      assign rem_in  = rem_r[s-1];
    end

    assign trial = {rem_in, word_in[NW-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = (trial >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        word_r[s] <= {word_in[NW-2:0], ge};
        rem_r[s]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      end
    end
  end

  assign quo_vld = vld_r[NW-1];
  assign quo     = word_r[NW-1];
  assign rem     = rem_r[NW-1];

endmodule
`default_nettype wire

// ----- rtl/gse_code.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// gse_code: truncated binary remainder and output register
// Forms the remainder codeword, lengths and the packed result beat.
// ---------------------------------------------------------------------------
module gse_code #(
  parameter int VALUE_BITS = gse_pkg::VALUE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire gse_pkg::cfg_t                   cfg,
  input  wire logic                            quo_vld,
  input  wire logic [VALUE_BITS:0]             quo,
  input  wire logic [gse_pkg::DIV_W-1:0]       rem,
  output logic                                 out_vld,
  output logic [gse_pkg::OUT_TDATA_W-1:0]      out_data
);

  localparam int OW  = gse_pkg::ONES_W;
  localparam int CW  = gse_pkg::CODE_W;
  localparam int LW  = gse_pkg::LEN_W;
  localparam int TW  = gse_pkg::TOTAL_W;
  localparam int PW  = gse_pkg::OUT_TDATA_W - gse_pkg::OUT_FIELDS_W;

  logic                            vld_r;
  logic [gse_pkg::OUT_TDATA_W-1:0] data_r;

  logic          short_code;
  logic [OW-1:0] ones;
  logic [CW-1:0] code;
  logic [LW-1:0] len;
  logic [TW-1:0] total;

  // remainders below t save one bit
  assign short_code = (rem < cfg.thresh);
  assign code       = short_code ? rem : CW'(rem + cfg.thresh);
  assign len        = short_code ? (cfg.log_m - LW'(1)) : cfg.log_m;
  assign ones       = OW'(quo);
  assign total      = TW'(ones) + TW'(1) + TW'(len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= quo_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= {PW'(0), total, len, code, ones};
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule
`default_nettype wire

// ----- rtl/golomb_signed_encoder.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// golomb_signed_encoder: Golomb coder for signed samples
// Maps each sample to a non-negative value, divides by m and reports the
// unary quotient and a truncated binary remainder codeword.
// ---------------------------------------------------------------------------
// Takes one sample beat per clock unless stalled and gives one result
// beat per sample, in order. Stages: one mapping stage, one restoring
// divider stage per bit of the mapped value (VALUE_BITS + 1 stages), and the
// codeword/output register. The whole pipeline advances together whenever
// the output register is empty or being taken, so a held out_tready freezes
// every stage in place and in_tready drops in the same cycle. Divisor and
// mode are read live by the stages using them: write them only while no beat
// is in flight. A divisor of zero acts as one; with m equal to one the
// remainder field is empty and the codeword is the unary part alone.
// ---------------------------------------------------------------------------
module golomb_signed_encoder #(
  parameter int VALUE_BITS = gse_pkg::VALUE_BITS_DEF,
  localparam int IN_TDATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,

  // configuration write port
  input  wire logic                              cfg_wr_en,
  input  wire logic [gse_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [gse_pkg::CFG_DATA_W-1:0]    cfg_wdata,

  // sample stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]             in_tdata,   // sample_value

  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // unary_ones[16:0], remainder_code[32:17], remainder_length[37:33],
  // total_length[54:38], zero pad above
  output logic [gse_pkg::OUT_TDATA_W-1:0]        out_tdata
);

  gse_pkg::cfg_t cfg;

  logic                          adv;        // pipeline advance
  logic                          map_vld;
  logic [VALUE_BITS:0]           map_val;
  logic                          quo_vld;
  logic [VALUE_BITS:0]           quo;
  logic [gse_pkg::DIV_W-1:0]     rem;

  // one shared advance: output slot free or being drained
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  gse_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // stage 1: sign handling
  gse_map #(
    .VALUE_BITS (VALUE_BITS)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .zigzag  (cfg.zigzag),
    .in_vld  (in_tvalid),
    .sample  (in_tdata[VALUE_BITS-1:0]),
    .map_vld (map_vld),
    .map_val (map_val)
  );

  // stages 2 .. VALUE_BITS+2: quotient and remainder, one bit each
  gse_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .divisor (cfg.divisor),
    .dvd_vld (map_vld),
    .dvd     (map_val),
    .quo_vld (quo_vld),
    .quo     (quo),
    .rem     (rem)
  );

  // last stage: truncated binary code, lengths, output register
  gse_code #(
    .VALUE_BITS (VALUE_BITS)
  ) u_code (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .cfg      (cfg),
    .quo_vld  (quo_vld),
    .quo      (quo),
    .rem      (rem),
    .out_vld  (out_tvalid),
    .out_data (out_tdata)
  );

endmodule
`default_nettype wire
